// ===== design/tpt_pkg.sv =====
// Shared types and constants for the trackball pointer tracker.
package tpt_pkg;

   localparam int STEP_W    = 7;
   localparam int HOLD_W    = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 48;
   localparam int QDEPTH    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PX    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_MS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_EN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DPAD_MODE  = 2'd3;

   localparam logic [STEP_W-1:0] STEP_PX_RST  = 7'd4;
   localparam logic [HOLD_W-1:0] LONG_MS_RST  = 16'd600;
   localparam logic [3:0]        DIR_IDLE     = 4'hF;

   typedef struct packed {
      logic [STEP_W-1:0] step_px;
      logic [HOLD_W-1:0] long_press_ms;
      logic              long_press_enable;
      logic              dpad_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [1:0]  det_x;
      logic signed [1:0]  det_y;
      logic               pressed;
      logic               new_click;
      logic               moved;
      logic [TIME_W-1:0]  now_ms;
   } event_type;

   typedef struct packed {
      logic              long_press_fire;
      logic signed [7:0] edge_over_y;
      logic signed [7:0] edge_over_x;
      logic              dpad_click;
      logic              dpad_event;
      logic signed [1:0] detent_y;
      logic signed [1:0] detent_x;
      logic              pointer_pressed;
      logic [7:0]        cursor_y;
      logic [8:0]        cursor_x;
   } result_type;

endpackage

// ===== design/tpt_front.sv =====
// Front end: takes polls, finds detents and click edges, pushes events.
module tpt_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         in_ready,
   input  logic [3:0]                   dir_levels,
   input  logic                         click_level,
   input  logic [tpt_pkg::TIME_W-1:0]   now_ms,
   output logic                         push,
   output tpt_pkg::event_type           evt
);

   logic [3:0] dir_last_ff, dir_last_in;
   logic       click_down_ff, click_down_in;
   logic [3:0] changed;
   logic       pressed;

   always_comb begin
      changed = dir_levels ^ dir_last_ff;
      pressed = ~click_level;
      push    = in_valid & in_ready;

      evt.det_x     = $signed({1'b0, changed[0]}) - $signed({1'b0, changed[2]});
      evt.det_y     = $signed({1'b0, changed[3]}) - $signed({1'b0, changed[1]});
      evt.pressed   = pressed;
      evt.new_click = pressed & ~click_down_ff;
      evt.moved     = |changed;
      evt.now_ms    = now_ms;

      dir_last_in   = push ? dir_levels : dir_last_ff;
      click_down_in = push ? pressed : click_down_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_last_ff   <= tpt_pkg::DIR_IDLE;
         click_down_ff <= 1'b0;
      end else begin
         dir_last_ff   <= dir_last_in;
         click_down_ff <= click_down_in;
      end
   end

endmodule

// ===== design/tpt_queue.sv =====
// Two-entry event queue between front and back end.
module tpt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tpt_pkg::event_type push_data,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output tpt_pkg::event_type pop_data
);

   localparam int PTR_W = $clog2(tpt_pkg::QDEPTH);

   tpt_pkg::event_type mem_ff [tpt_pkg::QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   always_comb begin
      not_full  = count_ff != (PTR_W+1)'(tpt_pkg::QDEPTH);
      not_empty = count_ff != '0;
      pop_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/tpt_axis.sv =====
// One cursor axis: step move, clamp to screen, overshoot.
module tpt_axis #(
   parameter int SIZE = 320,
   localparam int PW = $clog2(SIZE)
) (
   input  logic [PW-1:0]               pos,
   input  logic signed [1:0]           det,
   input  logic [tpt_pkg::STEP_W-1:0]  step_px,
   output logic [PW-1:0]               pos_next,
   output logic signed [7:0]           over
);

   localparam int XW = ((PW > tpt_pkg::STEP_W) ? PW : tpt_pkg::STEP_W) + 2;
   localparam logic signed [XW-1:0] LIM  = XW'(SIZE);
   localparam logic signed [XW-1:0] LAST = XW'(SIZE - 1);

   logic signed [XW-1:0] step_ext;
   logic signed [XW-1:0] delta;
   logic signed [XW-1:0] sum;
   logic signed [XW-1:0] over_ext;

   always_comb begin
      step_ext = $signed({{(XW-tpt_pkg::STEP_W){1'b0}}, step_px});
      case (det)
         2'sb01:  delta = step_ext;
         2'sb11:  delta = -step_ext;
         default: delta = '0;
      endcase
      sum      = $signed({{(XW-PW){1'b0}}, pos}) + delta;
      over_ext = '0;
      pos_next = sum[PW-1:0];
      if (det == 2'sb01 && sum >= LIM) begin
         over_ext = sum - LAST;
         pos_next = LAST[PW-1:0];
      end else if (det == 2'sb11 && sum < 0) begin
         over_ext = sum;
         pos_next = '0;
      end
      over = 8'(over_ext);
   end

endmodule

// ===== design/tpt_back.sv =====
// Back end: cursor, press timer, long press and the result register.
module tpt_back #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                clock,
   input  logic                reset,
   input  tpt_pkg::cfg_type    cfg,
   input  logic                evt_valid,
   input  tpt_pkg::event_type  evt,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output tpt_pkg::result_type out_data
);

   localparam int XPW = $clog2(SCREEN_WIDTH);
   localparam int YPW = $clog2(SCREEN_HEIGHT);
   localparam logic [XPW-1:0] X_RST = XPW'(SCREEN_WIDTH / 2);
   localparam logic [YPW-1:0] Y_RST = YPW'(SCREEN_HEIGHT / 2);

   logic [XPW-1:0]              pos_x_ff, pos_x_in, pos_x_mv;
   logic [YPW-1:0]              pos_y_ff, pos_y_in, pos_y_mv;
   logic [tpt_pkg::TIME_W-1:0]  start_ff, start_in;
   logic                        moved_held_ff, moved_held_in;
   logic                        lp_done_ff, lp_done_in;
   logic                        valid_ff, valid_in;
   tpt_pkg::result_type         data_ff, data_in;
   logic signed [7:0]           over_x, over_y;
   logic [tpt_pkg::TIME_W-1:0]  elapsed;
   logic                        fire;

   tpt_axis #(.SIZE(SCREEN_WIDTH)) u_axis_x (
      .pos      (pos_x_ff),
      .det      (evt.det_x),
      .step_px  (cfg.step_px),
      .pos_next (pos_x_mv),
      .over     (over_x)
   );

   tpt_axis #(.SIZE(SCREEN_HEIGHT)) u_axis_y (
      .pos      (pos_y_ff),
      .det      (evt.det_y),
      .step_px  (cfg.step_px),
      .pos_next (pos_y_mv),
      .over     (over_y)
   );

   always_comb begin
      pop = evt_valid & (~valid_ff | out_ready);

      start_in      = evt.new_click ? evt.now_ms : start_ff;
      moved_held_in = (evt.new_click ? 1'b0 : moved_held_ff) | (evt.pressed & evt.moved);
      elapsed       = evt.now_ms - start_in;
      fire = evt.pressed & ~(evt.new_click ? 1'b0 : lp_done_ff) & ~moved_held_in &
             cfg.long_press_enable &
             (elapsed >= {{(tpt_pkg::TIME_W-tpt_pkg::HOLD_W){1'b0}}, cfg.long_press_ms});
      lp_done_in    = (evt.new_click ? 1'b0 : lp_done_ff) | fire;

      data_in = '0;
      data_in.detent_x = evt.det_x;
      data_in.detent_y = evt.det_y;
      if (cfg.dpad_mode) begin
         pos_x_in = pos_x_ff;
         pos_y_in = pos_y_ff;
         data_in.dpad_event = (evt.det_x != 2'sb00) | (evt.det_y != 2'sb00) | evt.new_click;
         data_in.dpad_click = evt.new_click;
      end else begin
         pos_x_in = pos_x_mv;
         pos_y_in = pos_y_mv;
         data_in.pointer_pressed = evt.pressed & ~lp_done_in;
         data_in.long_press_fire = fire;
         data_in.edge_over_x     = evt.pressed ? 8'sd0 : over_x;
         data_in.edge_over_y     = evt.pressed ? 8'sd0 : over_y;
      end
      data_in.cursor_x = 9'(pos_x_in);
      data_in.cursor_y = 8'(pos_y_in);

      valid_in  = pop | (valid_ff & ~out_ready);
      out_valid = valid_ff;
      out_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff      <= X_RST;
         pos_y_ff      <= Y_RST;
         start_ff      <= '0;
         moved_held_ff <= 1'b0;
         lp_done_ff    <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            if (!cfg.dpad_mode) begin
               start_ff      <= start_in;
               moved_held_ff <= moved_held_in;
               lp_done_ff    <= lp_done_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/trackball_pointer_tracker_unit.sv =====
// Trackball pointer tracker top level: config registers, front, queue, back.
//
// Usage: each transaction on the req_ channel is one poll of the four direction
// pins, the active-low click pin and a millisecond time. Every poll yields
// exactly one transaction on the rsp_ channel with the cursor, detents,
// d-pad events, edge overshoot and the long press pulse.
// Configuration is written through csr_we/csr_index/csr_wdata while no poll
// is in flight; index 0 step_px, 1 long_press_ms, 2 long_press_enable,
// 3 dpad_mode.
// An accepted poll is written into the queue and then popped into the result
// register that drives rsp_. Throughput: one poll per cycle while rsp_tready
// stays high, as the back end updates cursor and timer for each popped event.
// Reset (synchronous, active high) restores register defaults, centers the
// cursor and empties the queue and result register.
// When rsp_tready is low the result holds; the two-entry queue absorbs polls
// and req_tready drops once it is full.
module trackball_pointer_tracker_unit #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // right_level, up_level, left_level, down_level, click_level, now_ms[31:0]
   input  logic [tpt_pkg::REQ_W-1:0]       req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_x[8:0], cursor_y[7:0], pointer_pressed, detent_x[1:0], detent_y[1:0],
   // dpad_event, dpad_click, edge_over_x[7:0], edge_over_y[7:0], long_press_fire
   output logic [tpt_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_we,
   input  logic [tpt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tpt_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   tpt_pkg::cfg_type    cfg_ff, cfg_in;
   tpt_pkg::event_type  push_evt, pop_evt;
   tpt_pkg::result_type rsp_data;
   logic                push, pop, q_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tpt_pkg::CSR_STEP_PX:   cfg_in.step_px = csr_wdata[tpt_pkg::STEP_W-1:0];
            tpt_pkg::CSR_LONG_MS:   cfg_in.long_press_ms = csr_wdata;
            tpt_pkg::CSR_LONG_EN:   cfg_in.long_press_enable = csr_wdata[0];
            tpt_pkg::CSR_DPAD_MODE: cfg_in.dpad_mode = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_px           <= tpt_pkg::STEP_PX_RST;
         cfg_ff.long_press_ms     <= tpt_pkg::LONG_MS_RST;
         cfg_ff.long_press_enable <= 1'b0;
         cfg_ff.dpad_mode         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .dir_levels  (req_tdata[3:0]),
      .click_level (req_tdata[4]),
      .now_ms      (req_tdata[36:5]),
      .push        (push),
      .evt         (push_evt)
   );

   tpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_evt),
      .not_full  (req_tready),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_evt)
   );

   tpt_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt_valid (q_not_empty),
      .evt       (pop_evt),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {{(tpt_pkg::RSP_W - $bits(tpt_pkg::result_type)){1'b0}}, rsp_data};

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the trackball pointer tracker unit.
`timescale 1ns / 100ps

module tb;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int RUN_LIMIT     = 600000;

   typedef struct {
      bit                  is_csr;
      logic [1:0]          idx;
      logic [15:0]         val;
      logic [3:0]          pins;
      logic                clk_lvl;
      logic [31:0]         t;
      bit                  typed;
      tpt_pkg::result_type want;
   } step_row_type;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [tpt_pkg::REQ_W-1:0]     req_tdata   = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [tpt_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_we      = 1'b0;
   logic [tpt_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   logic [tpt_pkg::CSR_DAT_W-1:0] csr_wdata   = '0;

   // predictor state, reset values
   tpt_pkg::cfg_type cfg     = '{tpt_pkg::STEP_PX_RST, tpt_pkg::LONG_MS_RST, 1'b0, 1'b0};
   logic [3:0]  prev_pins    = tpt_pkg::DIR_IDLE;
   logic        click_held   = 1'b0;
   logic        rolled       = 1'b0;
   logic        lp_done      = 1'b0;
   logic [31:0] press_t      = '0;
   int          cur_x        = SCREEN_WIDTH / 2;
   int          cur_y        = SCREEN_HEIGHT / 2;

   tpt_pkg::result_type due_reports[$];
   step_row_type        plan[$];
   int          mismatches   = 0;
   int          cycles       = 0;
   int          stall_left   = 0;
   bit          gaps_on      = 1'b1;
   bit          stalls_on    = 1'b1;

   trackball_pointer_tracker_unit #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("trackball_pointer_tracker_unit: mismatch");
         $finish;
      end
   end

   function automatic int clamp_axis(inout int pos, input int delta, input int span);
      int p;
      int over;
      p = pos + delta;
      over = 0;
      if (delta > 0 && p >= span) begin
         over = p - (span - 1);
         p = span - 1;
      end else if (delta < 0 && p < 0) begin
         over = p;
         p = 0;
      end
      pos = p;
      return over;
   endfunction

   function automatic tpt_pkg::result_type track_poll(input logic [3:0] pins,
                                                      input logic clk_lvl,
                                                      input logic [31:0] t);
      tpt_pkg::result_type r;
      logic [3:0]  diff;
      logic        down;
      logic        fresh;
      int          dx;
      int          dy;
      int          ox;
      int          oy;
      int          step;
      logic [31:0] held;
      r = '0;
      diff = pins ^ prev_pins;
      down = !clk_lvl;
      fresh = down && !click_held;
      dx = int'(diff[0]) - int'(diff[2]);
      dy = int'(diff[3]) - int'(diff[1]);
      prev_pins = pins;
      ox = 0;
      oy = 0;
      if (cfg.dpad_mode) begin
         r.dpad_event = (dx != 0) || (dy != 0) || fresh;
         r.dpad_click = fresh;
      end else begin
         step = int'(cfg.step_px);
         ox = clamp_axis(cur_x, dx * step, SCREEN_WIDTH);
         oy = clamp_axis(cur_y, dy * step, SCREEN_HEIGHT);
         if (fresh) begin
            press_t = t;
            rolled = 1'b0;
            lp_done = 1'b0;
         end
         if (down && diff != 4'h0) rolled = 1'b1;
         held = t - press_t;
         if (down && !lp_done && !rolled && cfg.long_press_enable &&
             held >= {16'h0, cfg.long_press_ms}) begin
            lp_done = 1'b1;
            r.long_press_fire = 1'b1;
         end
         if (down) begin
            ox = 0;
            oy = 0;
         end
         r.pointer_pressed = down && !lp_done;
      end
      click_held = down;
      r.cursor_x = cur_x[8:0];
      r.cursor_y = cur_y[7:0];
      r.detent_x = dx[1:0];
      r.detent_y = dy[1:0];
      r.edge_over_x = ox[7:0];
      r.edge_over_y = oy[7:0];
      return r;
   endfunction

   function automatic tpt_pkg::result_type rsp_of(int x, int y, int pr, int dx, int dy,
                                                  int ev, int dc, int ox, int oy, int fire);
      tpt_pkg::result_type r;
      r.cursor_x = x[8:0];
      r.cursor_y = y[7:0];
      r.pointer_pressed = (pr != 0);
      r.detent_x = dx[1:0];
      r.detent_y = dy[1:0];
      r.dpad_event = (ev != 0);
      r.dpad_click = (dc != 0);
      r.edge_over_x = ox[7:0];
      r.edge_over_y = oy[7:0];
      r.long_press_fire = (fire != 0);
      return r;
   endfunction

   function automatic step_row_type poll_row(logic [3:0] pins, logic clk_lvl, logic [31:0] t);
      step_row_type s;
      s.is_csr = 1'b0;
      s.idx = '0;
      s.val = '0;
      s.pins = pins;
      s.clk_lvl = clk_lvl;
      s.t = t;
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic step_row_type checked_row(logic [3:0] pins, logic clk_lvl,
                                                logic [31:0] t, tpt_pkg::result_type want);
      step_row_type s;
      s = poll_row(pins, clk_lvl, t);
      s.typed = 1'b1;
      s.want = want;
      return s;
   endfunction

   function automatic step_row_type csr_row(logic [1:0] idx, logic [15:0] val);
      step_row_type s;
      s = poll_row(4'h0, 1'b1, '0);
      s.is_csr = 1'b1;
      s.idx = idx;
      s.val = val;
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (!gaps_on || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 5);
   endfunction

   // result side: random stalls
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(99) < 25) begin
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(30, 5) : $urandom_range(2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0d: %s expected %0d, got %0d", cycles, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tpt_pkg::result_type got;
      tpt_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tpt_pkg::result_type'(rsp_tdata[$bits(tpt_pkg::result_type)-1:0]);
         if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0d: result transaction with none expected: %h", cycles, rsp_tdata);
         end else begin
            want = due_reports.pop_front();
            check_field("cursor_x", int'(got.cursor_x), int'(want.cursor_x));
            check_field("cursor_y", int'(got.cursor_y), int'(want.cursor_y));
            check_field("pointer_pressed", int'(got.pointer_pressed),
                        int'(want.pointer_pressed));
            check_field("detent_x", int'(got.detent_x), int'(want.detent_x));
            check_field("detent_y", int'(got.detent_y), int'(want.detent_y));
            check_field("dpad_event", int'(got.dpad_event), int'(want.dpad_event));
            check_field("dpad_click", int'(got.dpad_click), int'(want.dpad_click));
            check_field("edge_over_x", int'(got.edge_over_x), int'(want.edge_over_x));
            check_field("edge_over_y", int'(got.edge_over_y), int'(want.edge_over_y));
            check_field("long_press_fire", int'(got.long_press_fire),
                        int'(want.long_press_fire));
         end
      end
   end

   task automatic send_poll(logic [3:0] pins, logic clk_lvl, logic [31:0] t,
                            bit typed, tpt_pkg::result_type want);
      int                  idle;
      tpt_pkg::result_type predicted;
      idle = pick_gap();
      repeat (idle) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, t, clk_lvl, pins};
      do @(posedge clock); while (!req_tready);
      predicted = track_poll(pins, clk_lvl, t);
      due_reports.push_back(typed ? want : predicted);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         tpt_pkg::CSR_STEP_PX:   cfg.step_px = val[tpt_pkg::STEP_W-1:0];
         tpt_pkg::CSR_LONG_MS:   cfg.long_press_ms = val;
         tpt_pkg::CSR_LONG_EN:   cfg.long_press_enable = val[0];
         tpt_pkg::CSR_DPAD_MODE: cfg.dpad_mode = val[0];
         default: ;
      endcase
   endtask

   initial begin
      int          ph;
      int          k;
      int          r;
      int          fav;
      int          step;
      int          hold;
      bit          en;
      bit          dpad;
      logic [3:0]  lv;
      logic        ck;
      logic [31:0] tm;

      plan.push_back(checked_row(4'hF, 1'b1, 32'd0, rsp_of(160, 120, 0, 0, 0, 0, 0, 0, 0, 0)));
      plan.push_back(checked_row(4'hE, 1'b1, 32'd10, rsp_of(164, 120, 0, 1, 0, 0, 0, 0, 0, 0)));
      plan.push_back(checked_row(4'hC, 1'b1, 32'd20, rsp_of(164, 116, 0, 0, -1, 0, 0, 0, 0, 0)));
      plan.push_back(poll_row(4'h8, 1'b1, 32'd30));
      plan.push_back(poll_row(4'h0, 1'b1, 32'd40));
      // right and left together cancel
      plan.push_back(poll_row(4'h5, 1'b1, 32'd50));
      plan.push_back(csr_row(tpt_pkg::CSR_STEP_PX, 16'd127));
      plan.push_back(poll_row(4'h4, 1'b1, 32'd60));
      plan.push_back(checked_row(4'h5, 1'b1, 32'd70, rsp_of(319, 120, 0, 1, 0, 0, 0, 95, 0, 0)));
      plan.push_back(poll_row(4'h4, 1'b1, 32'd80));
      plan.push_back(csr_row(tpt_pkg::CSR_STEP_PX, 16'd0));
      plan.push_back(poll_row(4'h0, 1'b1, 32'd90));
      plan.push_back(csr_row(tpt_pkg::CSR_STEP_PX, 16'd64));
      plan.push_back(csr_row(tpt_pkg::CSR_LONG_EN, 16'd1));
      plan.push_back(csr_row(tpt_pkg::CSR_LONG_MS, 16'd0));
      // zero hold time fires on the press itself
      plan.push_back(checked_row(4'h0, 1'b0, 32'hFFFF_FFFF,
                                 rsp_of(319, 120, 0, 0, 0, 0, 0, 0, 0, 1)));
      plan.push_back(poll_row(4'h0, 1'b0, 32'h0000_0000));
      plan.push_back(poll_row(4'h0, 1'b1, 32'h0000_0001));
      plan.push_back(csr_row(tpt_pkg::CSR_LONG_MS, 16'hFFFF));
      // press timer across the time wrap
      plan.push_back(poll_row(4'h0, 1'b0, 32'hFFFF_FF00));
      plan.push_back(poll_row(4'h0, 1'b0, 32'h0000_FEFE));
      plan.push_back(poll_row(4'h0, 1'b0, 32'h0000_FEFF));
      plan.push_back(poll_row(4'h1, 1'b0, 32'h0000_FF00));
      plan.push_back(poll_row(4'h1, 1'b1, 32'h0000_FF10));
      // roll while held suppresses the long press
      plan.push_back(poll_row(4'h1, 1'b0, 32'd100));
      plan.push_back(poll_row(4'h3, 1'b0, 32'd200));
      plan.push_back(poll_row(4'h3, 1'b0, 32'h0001_0064));
      plan.push_back(poll_row(4'h3, 1'b1, 32'h0001_0070));
      plan.push_back(csr_row(tpt_pkg::CSR_DPAD_MODE, 16'd1));
      plan.push_back(poll_row(4'hB, 1'b1, 32'h0001_0080));
      plan.push_back(checked_row(4'hB, 1'b0, 32'h0001_0090,
                                 rsp_of(319, 56, 0, 0, 0, 1, 1, 0, 0, 0)));
      plan.push_back(poll_row(4'hB, 1'b0, 32'h0001_00A0));
      plan.push_back(poll_row(4'hB, 1'b1, 32'h0001_00B0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            send_poll(plan[i].pins, plan[i].clk_lvl, plan[i].t, plan[i].typed, plan[i].want);
         end
      end

      lv = 4'hB;
      ck = 1'b1;
      tm = 32'h0001_0100;
      fav = 0;
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin step = 4;   hold = 20;    en = 1; dpad = 0; end
            1: begin step = 127; hold = 0;     en = 1; dpad = 0; end
            2: begin step = 1;   hold = 65535; en = 1; dpad = 0; end
            3: begin step = 64;  hold = 600;   en = 0; dpad = 1; end
            4: begin step = 64;  hold = 100;   en = 0; dpad = 0; end
            5: begin
               step = $urandom_range(127);
               hold = $urandom_range(200, 1);
               en = 1'($urandom_range(1));
               dpad = 0;
            end
            6: begin
               step = $urandom_range(127);
               hold = $urandom_range(65535);
               en = 1;
               dpad = 1;
            end
            default: begin
               step = $urandom_range(64, 1);
               hold = $urandom_range(65535);
               en = 1;
               dpad = 0;
            end
         endcase
         gaps_on = (ph % 2) == 0;
         stalls_on = (ph % 3) != 2;
         drain();
         write_reg(tpt_pkg::CSR_STEP_PX, step[15:0]);
         write_reg(tpt_pkg::CSR_LONG_MS, hold[15:0]);
         write_reg(tpt_pkg::CSR_LONG_EN, {15'h0, en});
         write_reg(tpt_pkg::CSR_DPAD_MODE, {15'h0, dpad});
         for (k = 0; k < 235; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
               // noise
               lv = 4'($urandom_range(15));
               ck = 1'($urandom_range(1));
               tm = $urandom;
            end else begin
               if ($urandom_range(19) == 0) fav = $urandom_range(3);
               if ($urandom_range(99) < (ck ? 45 : 6)) lv[fav] = ~lv[fav];
               else if ($urandom_range(29) == 0) lv = lv ^ (r[0] ? 4'b0101 : 4'b1010);
               if ($urandom_range(11) == 0) ck = ~ck;
               r = $urandom_range(99);
               if (r < 85) tm = tm + $urandom_range(30);
               else if (r < 97) tm = tm + $urandom_range(2000, 100);
               else tm = tm + $urandom_range(70000, 60000);
            end
            send_poll(lv, ck, tm, 1'b0, '0);
            if ($urandom_range(199) == 0) drain();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("trackball_pointer_tracker_unit: match");
      else
         $display("trackball_pointer_tracker_unit: mismatch");
      $finish;
   end

endmodule
